>>> hw/rtl/smd_pkg.sv
// Package with the shared types, constants and double compare functions of the merge unit.
`default_nettype none
package smd_pkg;

   localparam int DEPTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 6;

   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_MERGE  = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [63:0]      value_res;
      logic             last;
      logic             empty_res;
      logic [POS_W-1:0] position;
   } rsp_type;

   // True when the bit pattern is a NaN.
   function automatic logic f_nan(input logic [63:0] a);
      f_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
   endfunction

   // IEEE less-than on doubles: NaN is unordered, +0 equals -0.
   function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
      logic both_zero;
      both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      if (f_nan(a) || f_nan(b) || both_zero) begin
         f_lt = 1'b0;
      end else if (a[63] != b[63]) begin
         f_lt = a[63];
      end else if (!a[63]) begin
         f_lt = a[62:0] < b[62:0];
      end else begin
         f_lt = a[62:0] > b[62:0];
      end
   endfunction

   // IEEE equality on doubles: NaN never equal, +0 equals -0.
   function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
      logic both_zero;
      both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
      f_eq = !f_nan(a) && !f_nan(b) && ((a == b) || both_zero);
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/smd_list_mem.sv
// One list store: synchronous memory with one write port and one registered read port.
`default_nettype none
module smd_list_mem (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [smd_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [63:0]               wr_data,
   input  wire logic [smd_pkg::ADDR_W-1:0] rd_addr,
   output logic      [63:0]               rd_data
);
   import smd_pkg::*;

   logic [63:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_merge_dedup_unit.sv
// Top level of the sorted list merge unit: list loading, merge walk and result register.
//
//   Port group   Dir   Handshake            Beat contents
//   req_*        in    req_valid/req_stall  req_data: kind, value
//   rsp_*        out   rsp_valid/rsp_stall  rsp_data: value_res, last, empty_res, position
//
// Loads are accepted back to back.
// A merge beat stalls the input until the walk ends: the walk advances one list
// entry per cycle while the result register is free, set by the single read port
// of each list memory, and the final step emits the last result.
// Reset clears both counts and the control state; list contents are not cleared.
// The walk pauses while the result register holds a beat that is stalled.
`default_nettype none
module sorted_merge_dedup_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire smd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output smd_pkg::rsp_type      rsp_data
);
   import smd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic [63:0]      pend_ff, pend_in;
   logic             pend_ok_ff, pend_ok_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic        wr_a, wr_b;
   logic [63:0] rd_a, rd_b;
   logic        accept, have_a, have_b, take_a, slot_free;
   logic [63:0] pick;

   smd_list_mem u_mem_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (idx_a_in[ADDR_W-1:0]),
      .rd_data (rd_a)
   );

   smd_list_mem u_mem_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[ADDR_W-1:0]),
      .wr_data (req_data.value),
      .rd_addr (idx_b_in[ADDR_W-1:0]),
      .rd_data (rd_b)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wr_a = accept && (req_data.kind == KIND_LOAD_A) && (cnt_a_ff < CNT_W'(DEPTH));
   assign wr_b = accept && (req_data.kind == KIND_LOAD_B) && (cnt_b_ff < CNT_W'(DEPTH));

   // Head selection: during a merge the read data holds the entry at the current index.
   assign have_a    = idx_a_ff < cnt_a_ff;
   assign have_b    = idx_b_ff < cnt_b_ff;
   assign take_a    = have_a && (!have_b || f_lt(rd_a, rd_b));
   assign pick      = take_a ? rd_a : rd_b;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Load, merge walk and result emission.
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      pend_in      = pend_ff;
      pend_ok_in   = pend_ok_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_a) begin
               cnt_a_in = cnt_a_ff + CNT_W'(1);
            end
            if (wr_b) begin
               cnt_b_in = cnt_b_ff + CNT_W'(1);
            end
            if (accept && (req_data.kind == KIND_MERGE)) begin
               idx_a_in   = '0;
               idx_b_in   = '0;
               pos_in     = '0;
               pend_ok_in = 1'b0;
               state_in   = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (slot_free) begin
               if (have_a || have_b) begin
                  if (take_a) begin
                     idx_a_in = idx_a_ff + CNT_W'(1);
                  end else begin
                     idx_b_in = idx_b_ff + CNT_W'(1);
                  end
                  // A new distinct value pushes out the pending one.
                  if (!pend_ok_ff || !f_eq(pend_ff, pick)) begin
                     pend_in    = pick;
                     pend_ok_in = 1'b1;
                     if (pend_ok_ff) begin
                        rsp_valid_in          = 1'b1;
                        rsp_data_in.value_res = pend_ff;
                        rsp_data_in.last      = 1'b0;
                        rsp_data_in.empty_res = 1'b0;
                        rsp_data_in.position  = pos_ff;
                        pos_in                = pos_ff + POS_W'(1);
                     end
                  end
               end else begin
                  // Both lists done: emit the final beat and clear the lists.
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.value_res = pend_ok_ff ? pend_ff : 64'd0;
                  rsp_data_in.last      = 1'b1;
                  rsp_data_in.empty_res = !pend_ok_ff;
                  rsp_data_in.position  = pend_ok_ff ? pos_ff : '0;
                  cnt_a_in              = '0;
                  cnt_b_in              = '0;
                  pend_ok_in            = 1'b0;
                  state_in              = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         pend_ok_ff   <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         pend_ok_ff   <= pend_ok_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The counts never pass the list depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNT_W'(DEPTH)) && (cnt_b_ff <= CNT_W'(DEPTH)))
      else $error("list count beyond depth");

   // The walk indexes never pass the counts.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (idx_a_ff <= cnt_a_ff) && (idx_b_ff <= cnt_b_ff))
      else $error("merge index beyond count");

   // Finishing a merge clears both lists and frees the input.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MERGE) && slot_free && !have_a && !have_b) |=>
      (cnt_a_ff == '0) && (cnt_b_ff == '0) && (state_ff == ST_IDLE) && rsp_valid_ff
      && rsp_data_ff.last)
      else $error("merge end not handled");

   // An empty-union beat is the only and final beat of its merge.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.empty_res) |->
      rsp_data_ff.last && (rsp_data_ff.position == '0) && (rsp_data_ff.value_res == 64'd0))
      else $error("bad empty beat");

endmodule
`default_nettype wire

>>> tb/sorted_merge_dedup_checker.sv
// Checker that watches both channels, predicts the merged union and compares each result beat.
`timescale 1ns / 1ps
module sorted_merge_dedup_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire smd_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire smd_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   import smd_pkg::*;

   logic [63:0]   shadow_a [DEPTH];
   logic [63:0]   shadow_b [DEPTH];
   int            fill_a;
   int            fill_b;
   rsp_type       union_queue [$];

   // IEEE ordering of doubles: NaN unordered, the two zeros equal.
   function automatic logic is_nan(input logic [63:0] a);
      return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
   endfunction

   function automatic logic dbl_less(input logic [63:0] a, input logic [63:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (a[62:0] == 0 && b[62:0] == 0) return 1'b0;
      if (a[63] != b[63]) return a[63];
      if (!a[63]) return a[62:0] < b[62:0];
      return a[62:0] > b[62:0];
   endfunction

   function automatic logic dbl_same(input logic [63:0] a, input logic [63:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return (a == b) || (a[62:0] == 0 && b[62:0] == 0);
   endfunction

   // Walk both shadow lists and queue the distinct union.
   task automatic predict_union();
      int          i;
      int          j;
      int          k;
      logic [63:0] pick;
      logic [63:0] prev;
      rsp_type     beat;
      i = 0; j = 0; k = 0; prev = '0;
      if (fill_a == 0 && fill_b == 0) begin
         beat = '{value_res: 64'd0, last: 1'b1, empty_res: 1'b1, position: '0};
         union_queue.push_back(beat);
         return;
      end
      while (i < fill_a || j < fill_b) begin
         if (i == fill_a) begin
            pick = shadow_b[j]; j++;
         end else if (j == fill_b) begin
            pick = shadow_a[i]; i++;
         end else if (dbl_less(shadow_a[i], shadow_b[j])) begin
            pick = shadow_a[i]; i++;
         end else begin
            pick = shadow_b[j]; j++;
         end
         if (k == 0 || !dbl_same(prev, pick)) begin
            beat = '{value_res: pick, last: 1'b0, empty_res: 1'b0, position: k[5:0]};
            union_queue.push_back(beat);
            prev = pick;
            k++;
         end
      end
      union_queue[union_queue.size() - 1].last = 1'b1;
      fill_a = 0;
      fill_b = 0;
   endtask

   // Track accepted request beats and check accepted result beats.
   always @(posedge clock) begin
      if (reset) begin
         fill_a <= 0;
         fill_b <= 0;
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            case (req_data.kind)
               KIND_LOAD_A: begin
                  if (fill_a < DEPTH) begin
                     shadow_a[fill_a] = req_data.value;
                     fill_a = fill_a + 1;
                  end
               end
               KIND_LOAD_B: begin
                  if (fill_b < DEPTH) begin
                     shadow_b[fill_b] = req_data.value;
                     fill_b = fill_b + 1;
                  end
               end
               KIND_MERGE: predict_union();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (union_queue.size() == 0) begin
               $error("unexpected result beat %h", rsp_data);
               fail_count = fail_count + 1;
            end else begin
               rsp_type want;
               want = union_queue.pop_front();
               if (rsp_data.value_res !== want.value_res) begin
                  $error("value_res expected %h actual %h", want.value_res, rsp_data.value_res);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %b actual %b", want.last, rsp_data.last);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $error("empty_res expected %b actual %b", want.empty_res, rsp_data.empty_res);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.position !== want.position) begin
                  $error("position expected %0d actual %0d", want.position, rsp_data.position);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      // Expected beats still outstanding.
      pending_count = union_queue.size();
   end
endmodule

>>> tb/sorted_merge_dedup_unit_test.sv
// Testbench top: drives load and merge beats, random result stalls, and reports the verdict.
`timescale 1ns / 1ps
module sorted_merge_dedup_unit_test;
   import smd_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   logic    hold_off;

   sorted_merge_dedup_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   sorted_merge_dedup_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random double patterns, biased toward a small pool so that ties occur.
   function automatic logic [63:0] pick_double();
      logic [63:0] pool [8];
      pool = '{64'h0, 64'h8000_0000_0000_0000, 64'h3ff0_0000_0000_0000,
               64'hbff0_0000_0000_0000, 64'h7ff0_0000_0000_0000,
               64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0001,
               64'h4000_0000_0000_0000};
      if ($urandom_range(0, 2) == 0) return pool[$urandom_range(0, 7)];
      return {$urandom(), $urandom()};
   endfunction

   // Offer one beat after a gap and wait until it is accepted.
   // Valid stays high after acceptance so that a beat with no gap follows directly.
   task automatic send_beat(input logic [1:0] kind, input logic [63:0] value,
                            input logic no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.kind  <= kind;
      req_data.value <= value;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Load a random ascending-ish list pair and merge it.
   task automatic send_set(input int len_a, input int len_b, input logic no_gap);
      logic [63:0] cur;
      cur = {1'b0, 11'h3f0, 52'd0};
      for (int n = 0; n < len_a + len_b; n++) begin
         if ($urandom_range(0, 1)) cur = cur + $urandom_range(0, 3) * 64'h1_0000_0000;
         send_beat((n < len_a) ? KIND_LOAD_A : KIND_LOAD_B,
                   ($urandom_range(0, 9) == 0) ? pick_double() : cur, no_gap);
      end
      send_beat(KIND_MERGE, {$urandom(), $urandom()}, no_gap);
   endtask

   // Receiver stall: random per beat, plus one long hold-off.
   initial begin
      int wait_n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else begin
            wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
            if (wait_n != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #20ms;
      $display("sorted_merge_dedup_unit test failed");
      $finish;
   end

   initial begin
      int drain;
      hold_off  = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty merge, zeros, infinities, NaN, unused kind.
      send_beat(KIND_MERGE, 64'd0, 1'b0);
      send_beat(KIND_LOAD_A, 64'h8000_0000_0000_0000, 1'b0);
      send_beat(KIND_LOAD_A, 64'h7ff0_0000_0000_0000, 1'b0);
      send_beat(KIND_LOAD_B, 64'h0, 1'b0);
      send_beat(KIND_LOAD_B, 64'h7ff8_0000_0000_0001, 1'b0);
      send_beat(KIND_LOAD_B, 64'hffff_ffff_ffff_ffff, 1'b0);
      send_beat(KIND_SPARE, 64'hffff_ffff_ffff_ffff, 1'b0);
      send_beat(KIND_MERGE, 64'hffff_ffff_ffff_ffff, 1'b0);
      send_beat(KIND_LOAD_A, 64'hfff0_0000_0000_0000, 1'b0);
      send_beat(KIND_MERGE, 64'd0, 1'b0);
      send_beat(KIND_LOAD_B, 64'h3ff0_0000_0000_0000, 1'b0);
      send_beat(KIND_MERGE, 64'd0, 1'b0);

      // Full lists with overflow loads, while the receiver holds off; the
      // sender moves on to the next set while the hold-off is still running.
      fork
         send_set(DEPTH + 2, DEPTH + 1, 1'b1);
         begin
            hold_off = 1'b1;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
      join_any

      // Random sets, mostly short.
      for (int s = 0; s < 5; s++) begin
         if ($urandom_range(0, 4) == 0) send_beat(KIND_SPARE, pick_double(), 1'b0);
         send_set($urandom_range(0, 5), $urandom_range(0, 5), ($urandom_range(0, 3) == 0));
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_count != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("sorted_merge_dedup_unit test passed");
      end else begin
         $display("sorted_merge_dedup_unit test failed");
      end
      $finish;
   end
endmodule
